// ----- hw/rtl/crs_pkg.sv -----
// Shared types and constants of the curve radius segmenter.
package crs_pkg;

  localparam int unsigned MAX_POINTS_DEF   = 65536;
  localparam int unsigned WINDOW_WIDTH_DEF = 5;

  localparam int unsigned ACC_W   = 196;
  localparam int unsigned AUX_W   = 65;
  localparam int unsigned RES_W   = 57;
  localparam int unsigned STEP_W  = 7;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned RAD_W   = 28;
  localparam int unsigned THR_W   = 25;
  localparam int unsigned SPD_W   = 16;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned NOUT    = 6;
  localparam int unsigned RCNT_W  = 3;

  localparam logic [RAD_W-1:0] RAD_MASK = '1;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_FLOOR      = 2'd1,
    REG_SPEED_HIGH = 2'd2,
    REG_SPEED_LOW  = 2'd3
  } reg_e;

  typedef struct packed {
    logic              start;
    op_e               op;
    logic [STEP_W-1:0] steps;
    logic              load_acc;
    logic [ACC_W-1:0]  acc_val;
    logic [ACC_W-1:0]  opnd;
    logic [AUX_W-1:0]  aux;
  } cmd_t;

endpackage

// ----- hw/rtl/curve_radius_segmenter.sv -----
// Top level of the curve radius segmenter: window, sequencer and output register.
//
// Path points enter one word at a time; the block is busy while it works on a point.
// The radius of point i leaves when point i+H arrives (H = (WINDOW_WIDTH-1)/2); a
// radius from a non-degenerate triple comes from the bit-serial unit that does every
// multiply, divide and root one bit (root: two bits) per cycle: two 32-bit products,
// k squared, three sums of squares, two 65-bit products, a 57-bit quotient and a
// 28-bit root. Capped radii skip the unit. A path-end word yields up to H+1 radii,
// then the path state clears. Output is a single register; a new point is taken
// while it waits.
module curve_radius_segmenter #(
  parameter int unsigned MAX_POINTS   = crs_pkg::MAX_POINTS_DEF,
  parameter int unsigned WINDOW_WIDTH = crs_pkg::WINDOW_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // coord_x[31:0], coord_y[63:32]
  input  logic        s_axis_tlast,  // path_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // start_index[15:0], stop_index[31:16], radius_value[59:32], curve_speed[75:60]
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tuser,  // record_kind
  output logic        m_axis_tlast,  // final_result
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned H      = (WINDOW_WIDTH - 1) / 2;
  localparam int unsigned SLOT_W = $clog2(WINDOW_WIDTH);
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS);
  localparam int unsigned CMP_W  = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;

  typedef enum logic [25:0] {
    ST_IDLE   = 26'h0000001,
    ST_PREP   = 26'h0000002,
    ST_LD_A   = 26'h0000004,
    ST_LD_B   = 26'h0000008,
    ST_LD_C   = 26'h0000010,
    ST_DIFF   = 26'h0000020,
    ST_PM     = 26'h0000040,
    ST_QM     = 26'h0000080,
    ST_KCALC  = 26'h0000100,
    ST_KK     = 26'h0000200,
    ST_S3A    = 26'h0000400,
    ST_S3B    = 26'h0000800,
    ST_S1A    = 26'h0001000,
    ST_S1B    = 26'h0002000,
    ST_S2A    = 26'h0004000,
    ST_S2B    = 26'h0008000,
    ST_N1     = 26'h0010000,
    ST_N2     = 26'h0020000,
    ST_DV     = 26'h0040000,
    ST_SQ     = 26'h0080000,
    ST_EMIT_R = 26'h0100000,
    ST_SPD    = 26'h0200000,
    ST_VM     = 26'h0400000,
    ST_VD     = 26'h0800000,
    ST_EMIT_C = 26'h1000000,
    ST_NEXT   = 26'h2000000
  } state_e;

  // configuration
  logic [crs_pkg::THR_W-1:0] thr_q, flr_q;
  logic [crs_pkg::SPD_W-1:0] vhi_q, vlo_q;

  // control
  state_e                     state_q, state_d;
  logic                       issued_q, issued_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [SLOT_W-1:0]          wp_q, wp_d;
  logic                       end_q, end_d;
  logic [SLOT_W-1:0]          off_q, off_d;
  logic [crs_pkg::RCNT_W-1:0] rcnt_q, rcnt_d;
  logic                       inside_q, inside_d;
  logic [crs_pkg::RAD_W-1:0]  prev_q, prev_d;
  logic [CNT_W-1:0]           cstart_q, cstart_d;
  logic [crs_pkg::RAD_W-1:0]  rmin_q, rmin_d;
  logic                       ovalid_q, ovalid_d;

  // payload
  logic [63:0]               win_q [WINDOW_WIDTH];
  logic [SLOT_W-1:0]         sa_q, sb_q, sc_q;
  logic [63:0]               p0_q, p1_q, p2_q;
  logic [31:0]               ux_q, uy_q, vx_q, vy_q, wx_q, wy_q;
  logic                      pn_q, qn_q;
  logic [63:0]               pm_q;
  logic [64:0]               k_q;
  logic [131:0]              d_q;
  logic [64:0]               s1_q, s3_q;
  logic [crs_pkg::RAD_W-1:0] r_q, rec_q;
  logic [crs_pkg::SPD_W-1:0] spd_q;
  logic                      okind_q, olast_q;
  logic [crs_pkg::IDX_W-1:0] ostart_q, ostop_q;
  logic [crs_pkg::RAD_W-1:0] orad_q;
  logic [crs_pkg::SPD_W-1:0] ospd_q;

  crs_pkg::cmd_t              cmd;
  logic                       busy;
  logic [crs_pkg::ACC_W-1:0]  acc;
  logic [crs_pkg::RES_W-1:0]  res;

  crs_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .busy_o (busy),
    .acc_o  (acc),
    .res_o  (res)
  );

  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] wp,
                                                 input logic [SLOT_W-1:0] off);
    logic [SLOT_W:0] t;
    t = (SLOT_W+1)'(wp) + (SLOT_W+1)'(WINDOW_WIDTH) - (SLOT_W+1)'(off);
    if (wp >= off) begin
      return wp - off;
    end else begin
      return t[SLOT_W-1:0];
    end
  endfunction

  function automatic logic [32:0] sdiff(input logic [31:0] a, input logic [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  function automatic logic [31:0] smag(input logic [32:0] v);
    logic [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  // derived values
  logic                      accept, out_free, unit_done;
  logic [CMP_W-1:0]          kx, ob, oa_w;
  logic [CNT_W-1:0]          idx;
  logic [SLOT_W-1:0]         off_a, off_c;
  logic [28:0]               cap10;
  logic [crs_pkg::RAD_W-1:0] cap;
  logic                      is_cap, nz;
  logic [32:0]               dux, duy, dvx, dvy, dwx, dwy;
  logic [64:0]               kval;
  logic [63:0]               pq_diff;
  logic [crs_pkg::RAD_W-1:0] thr_x, flr_x, sq_r, rec_val, base_min;
  logic                      below, prev_above, open_c, close_c;
  logic                      ovalid_set;
  logic [crs_pkg::THR_W-1:0] den, tdist;
  logic [crs_pkg::SPD_W-1:0] vdiff, vtop;
  logic [41:0]               vnum;
  logic                      emit_ok;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign unit_done = issued_q && !busy;

  assign kx    = CMP_W'(cnt_q);
  assign ob    = CMP_W'(off_q);
  assign idx   = CNT_W'(kx - ob);
  assign oa_w  = (ob + CMP_W'(H) < kx) ? ob + CMP_W'(H) : kx;
  assign off_a = SLOT_W'(oa_w);
  assign off_c = (off_q > SLOT_W'(H)) ? off_q - SLOT_W'(H) : '0;
  assign is_cap = (ob == kx) || (end_q && off_q == '0);
  assign nz    = ob != kx;

  assign cap10 = 29'({thr_q, 3'b000}) + 29'({thr_q, 1'b0});
  assign cap   = (cap10 > 29'(crs_pkg::RAD_MASK)) ? crs_pkg::RAD_MASK
                                                   : cap10[crs_pkg::RAD_W-1:0];

  assign dux = sdiff(p1_q[31:0], p0_q[31:0]);
  assign duy = sdiff(p1_q[63:32], p0_q[63:32]);
  assign dvx = sdiff(p2_q[31:0], p0_q[31:0]);
  assign dvy = sdiff(p2_q[63:32], p0_q[63:32]);
  assign dwx = sdiff(p1_q[31:0], p2_q[31:0]);
  assign dwy = sdiff(p1_q[63:32], p2_q[63:32]);

  assign pq_diff = (pm_q >= acc[63:0]) ? pm_q - acc[63:0] : acc[63:0] - pm_q;
  assign kval    = (pn_q != qn_q) ? 65'(pm_q) + 65'(acc[63:0]) : 65'(pq_diff);

  assign sq_r = (res[crs_pkg::RAD_W-1:0] < cap) ? res[crs_pkg::RAD_W-1:0] : cap;

  assign thr_x      = crs_pkg::RAD_W'(thr_q);
  assign flr_x      = crs_pkg::RAD_W'(flr_q);
  assign below      = r_q <= thr_x;
  assign prev_above = prev_q > thr_x;
  assign open_c     = nz && !inside_q && below && prev_above;
  assign close_c    = nz && inside_q && !prev_above && !below;
  assign rec_val    = (rmin_q < flr_x) ? flr_x : rmin_q;
  assign base_min   = close_c ? crs_pkg::RAD_MASK : rmin_q;

  assign den   = thr_q - flr_q;
  assign tdist = thr_q - rec_q[crs_pkg::THR_W-1:0];
  assign vdiff = vhi_q - vlo_q;
  assign vtop  = (vhi_q >= vlo_q) ? vhi_q : vlo_q;
  assign vnum  = 42'(acc[40:0]) + 42'(den) - 42'd1;
  assign emit_ok = rcnt_q < crs_pkg::RCNT_W'(crs_pkg::NOUT);

  // command to the shared unit
  always_comb begin
    cmd          = '0;
    cmd.op       = crs_pkg::OP_MUL;
    cmd.load_acc = 1'b1;
    unique case (state_q)
      ST_PM: begin
        cmd.steps = crs_pkg::STEP_W'(32);
        cmd.opnd  = crs_pkg::ACC_W'(ux_q);
        cmd.aux   = crs_pkg::AUX_W'(vy_q);
      end
      ST_QM: begin
        cmd.steps = crs_pkg::STEP_W'(32);
        cmd.opnd  = crs_pkg::ACC_W'(uy_q);
        cmd.aux   = crs_pkg::AUX_W'(vx_q);
      end
      ST_KK: begin
        cmd.steps = crs_pkg::STEP_W'(65);
        cmd.opnd  = crs_pkg::ACC_W'(k_q);
        cmd.aux   = k_q;
      end
      ST_S3A, ST_S3B: begin
        cmd.steps    = crs_pkg::STEP_W'(32);
        cmd.load_acc = state_q == ST_S3A;
        cmd.opnd     = crs_pkg::ACC_W'((state_q == ST_S3A) ? vx_q : vy_q);
        cmd.aux      = crs_pkg::AUX_W'((state_q == ST_S3A) ? vx_q : vy_q);
      end
      ST_S1A, ST_S1B: begin
        cmd.steps    = crs_pkg::STEP_W'(32);
        cmd.load_acc = state_q == ST_S1A;
        cmd.opnd     = crs_pkg::ACC_W'((state_q == ST_S1A) ? ux_q : uy_q);
        cmd.aux      = crs_pkg::AUX_W'((state_q == ST_S1A) ? ux_q : uy_q);
      end
      ST_S2A, ST_S2B: begin
        cmd.steps    = crs_pkg::STEP_W'(32);
        cmd.load_acc = state_q == ST_S2A;
        cmd.opnd     = crs_pkg::ACC_W'((state_q == ST_S2A) ? wx_q : wy_q);
        cmd.aux      = crs_pkg::AUX_W'((state_q == ST_S2A) ? wx_q : wy_q);
      end
      ST_N1: begin
        cmd.steps = crs_pkg::STEP_W'(65);
        cmd.opnd  = crs_pkg::ACC_W'(s1_q);
        cmd.aux   = acc[crs_pkg::AUX_W-1:0];
      end
      ST_N2: begin
        cmd.steps = crs_pkg::STEP_W'(65);
        cmd.opnd  = acc;
        cmd.aux   = s3_q;
      end
      ST_DV: begin
        cmd.op       = crs_pkg::OP_DIV;
        cmd.steps    = crs_pkg::STEP_W'(crs_pkg::RES_W);
        cmd.load_acc = 1'b0;
        cmd.opnd     = crs_pkg::ACC_W'({d_q, 56'd0});
      end
      ST_SQ: begin
        cmd.op    = crs_pkg::OP_SQRT;
        cmd.steps = crs_pkg::STEP_W'(crs_pkg::RAD_W);
        cmd.aux   = crs_pkg::AUX_W'(res[55:0]);
      end
      ST_VM: begin
        cmd.steps = crs_pkg::STEP_W'(crs_pkg::SPD_W);
        cmd.opnd  = crs_pkg::ACC_W'(tdist);
        cmd.aux   = crs_pkg::AUX_W'(vdiff);
      end
      ST_VD: begin
        cmd.op      = crs_pkg::OP_DIV;
        cmd.steps   = crs_pkg::STEP_W'(crs_pkg::SPD_W);
        cmd.acc_val = crs_pkg::ACC_W'(vnum);
        cmd.opnd    = crs_pkg::ACC_W'({den, 15'd0});
      end
      default: begin
        cmd.steps = '0;
      end
    endcase
    cmd.start = !issued_q && (state_q == ST_PM || state_q == ST_QM || state_q == ST_KK
              || state_q == ST_S3A || state_q == ST_S3B || state_q == ST_S1A
              || state_q == ST_S1B || state_q == ST_S2A || state_q == ST_S2B
              || state_q == ST_N1 || state_q == ST_N2 || state_q == ST_DV
              || (state_q == ST_SQ && !res[56]) || state_q == ST_VM
              || state_q == ST_VD);
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    issued_d   = issued_q;
    cnt_d      = cnt_q;
    wp_d       = wp_q;
    end_d      = end_q;
    off_d      = off_q;
    rcnt_d     = rcnt_q;
    inside_d   = inside_q;
    prev_d     = prev_q;
    cstart_d   = cstart_q;
    rmin_d     = rmin_q;
    ovalid_set = 1'b0;

    if (cmd.start) begin
      issued_d = 1'b1;
    end else if (unit_done) begin
      issued_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          end_d  = s_axis_tlast || (cnt_q >= CNT_W'(MAX_POINTS - 1));
          rcnt_d = '0;
          if (end_d) begin
            off_d   = (kx < CMP_W'(H)) ? SLOT_W'(cnt_q) : SLOT_W'(H);
            state_d = ST_PREP;
          end else if (kx >= CMP_W'(H)) begin
            off_d   = SLOT_W'(H);
            state_d = ST_PREP;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
            wp_d  = (wp_q == SLOT_W'(WINDOW_WIDTH - 1)) ? '0 : wp_q + SLOT_W'(1);
          end
        end
      end
      ST_PREP:  state_d = is_cap ? ST_EMIT_R : ST_LD_A;
      ST_LD_A:  state_d = ST_LD_B;
      ST_LD_B:  state_d = ST_LD_C;
      ST_LD_C:  state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_PM;
      ST_PM:    if (unit_done) state_d = ST_QM;
      ST_QM:    if (unit_done) state_d = ST_KCALC;
      ST_KCALC: state_d = (kval == '0) ? ST_EMIT_R : ST_KK;
      ST_KK:    if (unit_done) state_d = ST_S3A;
      ST_S3A:   if (unit_done) state_d = ST_S3B;
      ST_S3B:   if (unit_done) state_d = ST_S1A;
      ST_S1A:   if (unit_done) state_d = ST_S1B;
      ST_S1B:   if (unit_done) state_d = ST_S2A;
      ST_S2A:   if (unit_done) state_d = ST_S2B;
      ST_S2B:   if (unit_done) state_d = ST_N1;
      ST_N1:    if (unit_done) state_d = ST_N2;
      ST_N2:    if (unit_done) state_d = ST_DV;
      ST_DV:    if (unit_done) state_d = ST_SQ;
      ST_SQ: begin
        if ((!issued_q && res[56]) || unit_done) begin
          state_d = ST_EMIT_R;
        end
      end
      ST_EMIT_R: begin
        if (out_free) begin
          ovalid_set = emit_ok;
          if (emit_ok) begin
            rcnt_d = rcnt_q + crs_pkg::RCNT_W'(1);
          end
          prev_d = r_q;
          if (open_c) begin
            inside_d = 1'b1;
            cstart_d = idx;
          end else if (close_c) begin
            inside_d = 1'b0;
          end
          rmin_d = (nz && inside_d && base_min > r_q) ? r_q : base_min;
          state_d = close_c ? ST_SPD : ST_NEXT;
        end
      end
      ST_SPD: state_d = (thr_q > flr_q && vhi_q >= vlo_q) ? ST_VM : ST_EMIT_C;
      ST_VM:  if (unit_done) state_d = ST_VD;
      ST_VD:  if (unit_done) state_d = ST_EMIT_C;
      ST_EMIT_C: begin
        if (out_free) begin
          ovalid_set = emit_ok;
          if (emit_ok) begin
            rcnt_d = rcnt_q + crs_pkg::RCNT_W'(1);
          end
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (!end_q || off_q == '0) begin
          state_d = ST_IDLE;
          if (end_q) begin
            cnt_d    = '0;
            wp_d     = '0;
            prev_d   = '0;
            inside_d = 1'b0;
            cstart_d = '0;
            rmin_d   = crs_pkg::RAD_MASK;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
            wp_d  = (wp_q == SLOT_W'(WINDOW_WIDTH - 1)) ? '0 : wp_q + SLOT_W'(1);
          end
        end else begin
          off_d   = off_q - SLOT_W'(1);
          state_d = ST_PREP;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    ovalid_d = ovalid_set || (ovalid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      cnt_q    <= '0;
      wp_q     <= '0;
      end_q    <= 1'b0;
      off_q    <= '0;
      rcnt_q   <= '0;
      inside_q <= 1'b0;
      prev_q   <= '0;
      cstart_q <= '0;
      rmin_q   <= crs_pkg::RAD_MASK;
      ovalid_q <= 1'b0;
      thr_q    <= '0;
      flr_q    <= '0;
      vhi_q    <= '0;
      vlo_q    <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      cnt_q    <= cnt_d;
      wp_q     <= wp_d;
      end_q    <= end_d;
      off_q    <= off_d;
      rcnt_q   <= rcnt_d;
      inside_q <= inside_d;
      prev_q   <= prev_d;
      cstart_q <= cstart_d;
      rmin_q   <= rmin_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i) begin
        unique case (crs_pkg::reg_e'(cfg_index_i))
          crs_pkg::REG_THRESHOLD:  thr_q <= cfg_data_i[crs_pkg::THR_W-1:0];
          crs_pkg::REG_FLOOR:      flr_q <= cfg_data_i[crs_pkg::THR_W-1:0];
          crs_pkg::REG_SPEED_HIGH: vhi_q <= cfg_data_i[crs_pkg::SPD_W-1:0];
          crs_pkg::REG_SPEED_LOW:  vlo_q <= cfg_data_i[crs_pkg::SPD_W-1:0];
          default:                 thr_q <= thr_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q[wp_q] <= s_axis_tdata;
    end
    if (state_q == ST_PREP) begin
      sa_q <= slot_of(wp_q, off_a);
      sb_q <= slot_of(wp_q, off_q);
      sc_q <= slot_of(wp_q, off_c);
      r_q  <= cap;
    end
    if (state_q == ST_LD_A) p0_q <= win_q[sa_q];
    if (state_q == ST_LD_B) p1_q <= win_q[sb_q];
    if (state_q == ST_LD_C) p2_q <= win_q[sc_q];
    if (state_q == ST_DIFF) begin
      ux_q <= smag(dux);
      uy_q <= smag(duy);
      vx_q <= smag(dvx);
      vy_q <= smag(dvy);
      wx_q <= smag(dwx);
      wy_q <= smag(dwy);
      pn_q <= dux[32] ^ dvy[32];
      qn_q <= duy[32] ^ dvx[32];
    end
    if (state_q == ST_PM && unit_done) pm_q <= acc[63:0];
    if (state_q == ST_KCALC) k_q <= kval;
    if (state_q == ST_KK && unit_done) d_q <= {acc[129:0], 2'b00};
    if (state_q == ST_S3B && unit_done) s3_q <= acc[64:0];
    if (state_q == ST_S1B && unit_done) s1_q <= acc[64:0];
    if (state_q == ST_SQ && unit_done) r_q <= sq_r;
    if (state_q == ST_EMIT_R && out_free) begin
      if (close_c) rec_q <= rec_val;
      if (emit_ok) begin
        okind_q  <= 1'b0;
        ostart_q <= crs_pkg::IDX_W'(idx);
        ostop_q  <= '0;
        orad_q   <= r_q;
        ospd_q   <= '0;
        olast_q  <= end_q && ((off_q == '0 && !close_c)
                              || rcnt_q == crs_pkg::RCNT_W'(crs_pkg::NOUT - 1));
      end
    end
    if (state_q == ST_SPD) spd_q <= (thr_q < flr_q) ? vlo_q : vtop;
    if (state_q == ST_VD && unit_done) spd_q <= vhi_q - res[crs_pkg::SPD_W-1:0];
    if (state_q == ST_EMIT_C && out_free && emit_ok) begin
      okind_q  <= 1'b1;
      ostart_q <= crs_pkg::IDX_W'(cstart_q);
      ostop_q  <= crs_pkg::IDX_W'(idx);
      orad_q   <= rec_q;
      ospd_q   <= spd_q;
      olast_q  <= end_q && (off_q == '0
                            || rcnt_q == crs_pkg::RCNT_W'(crs_pkg::NOUT - 1));
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'b0000, ospd_q, orad_q, ostop_q, ostart_q};
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

endmodule

// ----- hw/rtl/crs_unit.sv -----
// Bit-serial shift-add multiply, restoring divide and square root unit.
module crs_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  crs_pkg::cmd_t               cmd_i,
  output logic                        busy_o,
  output logic [crs_pkg::ACC_W-1:0]   acc_o,
  output logic [crs_pkg::RES_W-1:0]   res_o
);

  crs_pkg::op_e                 op_q;
  logic [crs_pkg::STEP_W-1:0]   cnt_q;
  logic [crs_pkg::ACC_W-1:0]    acc_q;
  logic [crs_pkg::ACC_W-1:0]    opnd_q;
  logic [crs_pkg::AUX_W-1:0]    aux_q;
  logic [crs_pkg::RES_W-1:0]    res_q;

  logic [crs_pkg::ACC_W-1:0]    remsh;
  logic [crs_pkg::ACC_W-1:0]    trial;
  logic [crs_pkg::ACC_W-1:0]    add_x;
  logic [crs_pkg::ACC_W-1:0]    add_y;
  logic [crs_pkg::ACC_W:0]      sum;
  logic                         carry;

  assign remsh = {acc_q[crs_pkg::ACC_W-3:0], aux_q[55:54]};
  assign trial = crs_pkg::ACC_W'({res_q, 2'b01});

  // one adder; subtraction as x + ~y + 1, carry out means no borrow
  always_comb begin
    unique case (op_q)
      crs_pkg::OP_MUL: begin
        add_x = acc_q;
        add_y = opnd_q;
      end
      crs_pkg::OP_SQRT: begin
        add_x = remsh;
        add_y = ~trial;
      end
      default: begin
        add_x = acc_q;
        add_y = ~opnd_q;
      end
    endcase
  end

  assign sum   = {1'b0, add_x} + {1'b0, add_y}
               + (crs_pkg::ACC_W+1)'(op_q != crs_pkg::OP_MUL);
  assign carry = sum[crs_pkg::ACC_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= crs_pkg::OP_MUL;
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      op_q  <= cmd_i.op;
      cnt_q <= cmd_i.steps;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - crs_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      if (cmd_i.load_acc) begin
        acc_q <= cmd_i.acc_val;
      end
      opnd_q <= cmd_i.opnd;
      aux_q  <= cmd_i.aux;
      res_q  <= '0;
    end else if (cnt_q != '0) begin
      unique case (op_q)
        crs_pkg::OP_MUL: begin
          if (aux_q[0]) begin
            acc_q <= sum[crs_pkg::ACC_W-1:0];
          end
          opnd_q <= {opnd_q[crs_pkg::ACC_W-2:0], 1'b0};
          aux_q  <= {1'b0, aux_q[crs_pkg::AUX_W-1:1]};
        end
        crs_pkg::OP_SQRT: begin
          acc_q <= carry ? sum[crs_pkg::ACC_W-1:0] : remsh;
          res_q <= {res_q[crs_pkg::RES_W-2:0], carry};
          aux_q <= {aux_q[crs_pkg::AUX_W-3:0], 2'b00};
        end
        default: begin
          if (carry) begin
            acc_q <= sum[crs_pkg::ACC_W-1:0];
          end
          res_q  <= {res_q[crs_pkg::RES_W-2:0], carry};
          opnd_q <= {1'b0, opnd_q[crs_pkg::ACC_W-1:1]};
        end
      endcase
    end
  end

  assign busy_o = cnt_q != '0;
  assign acc_o  = acc_q;
  assign res_o  = res_q;

endmodule
